FILE: rtl/plb_pkg.sv
`timescale 1ns / 1ps
package plb_pkg;

	localparam int NUM_BOXES   = 4;
	localparam int ROW_BITS    = 10;
	localparam int COL_BITS    = 11;
	localparam int COORD_W     = 16;
	localparam int CORNER_W    = 3 * COORD_W;
	localparam int NUM_CFG     = 2 * NUM_BOXES;
	localparam int CFG_IDX_W   = 3;
	localparam int LABEL_W     = 3;
	localparam int BOX_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input tdata: x, y, z, row, col from bit 0 up, zero filled to bytes
	localparam int IN_BITS   = CORNER_W + ROW_BITS + COL_BITS;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// output tdata: label, box_index, box_found, row_min, row_max, col_min, col_max
	localparam int OUT_BITS   = LABEL_W + BOX_IDX_W + 1 + 2 * ROW_BITS + 2 * COL_BITS;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic {
		KIND_LABEL  = 1'b0,
		KIND_REPORT = 1'b1
	} plb_kind_t;

	typedef enum logic {
		BK_PIXEL,
		BK_REPORT
	} plb_back_state_t;

	// one classified pixel waiting for the back end
	typedef struct packed {
		logic [LABEL_W-1:0]  label;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                frame_end;
	} plb_entry_t;

endpackage

FILE: rtl/plb_front.sv
`timescale 1ns / 1ps
module plb_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [plb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plb_pkg::CORNER_W-1:0]        cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [plb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	input  logic                                s_axis_tlast,
	input  logic                                q_full,
	output logic                                push,
	output plb_pkg::plb_entry_t                 push_entry
);
	import plb_pkg::*;

	logic [CORNER_W-1:0]       corner_q [NUM_CFG];
	logic signed [COORD_W-1:0] pt [3];
	logic                      pt_valid;
	logic [NUM_BOXES-1:0]      hit;
	logic [LABEL_W-1:0]        label;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) corner_q[i] <= '0;
		end else if (cfg_wen && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(NUM_CFG))) begin
			corner_q[cfg_index] <= cfg_data;
		end
	end

	assign pt[0] = s_axis_tdata[COORD_W-1:0];
	assign pt[1] = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign pt[2] = s_axis_tdata[3*COORD_W-1:2*COORD_W];
	// an all-zero point means no depth reading
	assign pt_valid = (pt[0] != '0) || (pt[1] != '0) || (pt[2] != '0);

	always_comb begin
		logic signed [COORD_W-1:0] lo;
		logic signed [COORD_W-1:0] hi;
		for (int k = 0; k < NUM_BOXES; k++) begin
			hit[k] = 1'b1;
			for (int a = 0; a < 3; a++) begin
				lo = corner_q[2*k][a*COORD_W +: COORD_W];
				hi = corner_q[2*k+1][a*COORD_W +: COORD_W];
				if (pt[a] < lo || pt[a] > hi) hit[k] = 1'b0;
			end
		end
	end

	// first box that holds the point wins
	always_comb begin
		label = '0;
		if (pt_valid) begin
			for (int k = NUM_BOXES - 1; k >= 0; k--) begin
				if (hit[k]) label = LABEL_W'(k + 1);
			end
		end
	end

	assign s_axis_tready        = !q_full;
	assign push                 = s_axis_tvalid && !q_full;
	assign push_entry.label     = label;
	assign push_entry.row       = s_axis_tdata[CORNER_W +: ROW_BITS];
	assign push_entry.col       = s_axis_tdata[CORNER_W+ROW_BITS +: COL_BITS];
	assign push_entry.frame_end = s_axis_tlast;

endmodule

FILE: rtl/plb_queue.sv
`timescale 1ns / 1ps
module plb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  plb_pkg::plb_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                q_valid,
	output plb_pkg::plb_entry_t head
);
	import plb_pkg::*;

	plb_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];

endmodule

FILE: rtl/plb_back.sv
`timescale 1ns / 1ps
module plb_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  plb_pkg::plb_entry_t               head,
	output logic                              pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [plb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // label, box_index, box_found, row_min, row_max, col_min, col_max
	output logic                              m_axis_tlast,
	output logic                              m_axis_tuser    // kind
);
	import plb_pkg::*;

	plb_back_state_t state_q, state_d;
	logic [BOX_IDX_W-1:0] rpt_q;
	logic                 load;
	logic                 rpt_load;
	logic                 rpt_done;

	logic                 seen_q [NUM_BOXES];
	logic [ROW_BITS-1:0]  rmin_q [NUM_BOXES];
	logic [ROW_BITS-1:0]  rmax_q [NUM_BOXES];
	logic [COL_BITS-1:0]  cmin_q [NUM_BOXES];
	logic [COL_BITS-1:0]  cmax_q [NUM_BOXES];

	logic                 ov_q;
	plb_kind_t            okind_q, okind_d;
	logic [LABEL_W-1:0]   olabel_q, olabel_d;
	logic [BOX_IDX_W-1:0] obox_q, obox_d;
	logic                 ofound_q, ofound_d;
	logic [ROW_BITS-1:0]  ormin_q, ormin_d, ormax_q, ormax_d;
	logic [COL_BITS-1:0]  ocmin_q, ocmin_d, ocmax_q, ocmax_d;
	logic                 olast_q, olast_d;

	// the output register frees up when it is empty or its transfer completes
	assign load     = !ov_q || m_axis_tready;
	assign pop      = (state_q == BK_PIXEL) && q_valid && load;
	assign rpt_load = (state_q == BK_REPORT) && load;
	assign rpt_done = rpt_load && (rpt_q == BOX_IDX_W'(NUM_BOXES - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_PIXEL:  if (pop && head.frame_end) state_d = BK_REPORT;
			BK_REPORT: if (rpt_done) state_d = BK_PIXEL;
			default:   state_d = BK_PIXEL;
		endcase
	end

	always_comb begin
		okind_d  = KIND_LABEL;
		olabel_d = '0;
		obox_d   = '0;
		ofound_d = 1'b0;
		ormin_d  = '0;
		ormax_d  = '0;
		ocmin_d  = '0;
		ocmax_d  = '0;
		olast_d  = 1'b0;
		unique case (state_q)
			BK_PIXEL: begin
				olabel_d = head.label;
				olast_d  = !head.frame_end;
			end
			BK_REPORT: begin
				okind_d  = KIND_REPORT;
				obox_d   = rpt_q;
				ofound_d = seen_q[rpt_q];
				ormin_d  = rmin_q[rpt_q];
				ormax_d  = rmax_q[rpt_q];
				ocmin_d  = cmin_q[rpt_q];
				ocmax_d  = cmax_q[rpt_q];
				olast_d  = (rpt_q == BOX_IDX_W'(NUM_BOXES - 1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_PIXEL;
			rpt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rpt_load) rpt_q <= rpt_done ? '0 : rpt_q + 1'b1;
			if (load) ov_q <= pop || rpt_load;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || rpt_load) begin
			okind_q  <= okind_d;
			olabel_q <= olabel_d;
			obox_q   <= obox_d;
			ofound_q <= ofound_d;
			ormin_q  <= ormin_d;
			ormax_q  <= ormax_d;
			ocmin_q  <= ocmin_d;
			ocmax_q  <= ocmax_d;
			olast_q  <= olast_d;
		end
	end

	// per-box extents, cleared after the last report of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BOXES; k++) begin
				seen_q[k] <= 1'b0;
				rmin_q[k] <= '1;
				rmax_q[k] <= '0;
				cmin_q[k] <= '1;
				cmax_q[k] <= '0;
			end
		end else if (rpt_done) begin
			for (int k = 0; k < NUM_BOXES; k++) begin
				seen_q[k] <= 1'b0;
				rmin_q[k] <= '1;
				rmax_q[k] <= '0;
				cmin_q[k] <= '1;
				cmax_q[k] <= '0;
			end
		end else if (pop) begin
			for (int k = 0; k < NUM_BOXES; k++) begin
				if (head.label == LABEL_W'(k + 1)) begin
					seen_q[k] <= 1'b1;
					if (head.row < rmin_q[k]) rmin_q[k] <= head.row;
					if (head.row > rmax_q[k]) rmax_q[k] <= head.row;
					if (head.col < cmin_q[k]) cmin_q[k] <= head.col;
					if (head.col > cmax_q[k]) cmax_q[k] <= head.col;
				end
			end
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = OUT_DATA_W'({ocmax_q, ocmin_q, ormax_q, ormin_q,
		ofound_q, obox_q, olabel_q});

	a_idle_counter: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_PIXEL |-> rpt_q == '0)
		else $error("report counter left nonzero outside report phase");

	a_clear_after_reports: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_done |=> !seen_q[0] && rmax_q[0] == '0 && cmax_q[0] == '0)
		else $error("extents not cleared after frame reports");

	a_label_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && okind_q == KIND_LABEL |-> olabel_q <= LABEL_W'(NUM_BOXES))
		else $error("label result names a box that does not exist");

	a_no_pop_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_REPORT |-> !pop)
		else $error("queue popped during report phase");

endmodule

FILE: rtl/point_box_pixel_labeler_top.sv
`timescale 1ns / 1ps
// Labels a stream of per-pixel 3D points against up to four inclusive 3D boxes and
// tracks each box's row/column extent. One pixel is taken per clock while the queue
// is not full; each pixel gives one label result, and a frame-end pixel is followed
// by one extent report per box. A four-entry queue between the classifier and the
// extent tracker takes up most of the report phase and short output stalls; with pixels
// arriving back to back and the output always ready, the input is still held off while
// the queue is full after each frame-end pixel. A label result passes through the queue
// and the output register. Box corners are written on the cfg port: register 2k is
// box k's low corner, 2k+1 its high corner, x/y/z as signed 16-bit fields from bit 0
// up. The user must write them only while the block is idle; the block does not enforce it.
module point_box_pixel_labeler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [plb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plb_pkg::CORNER_W-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [plb_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // point_x, point_y, point_z, pixel_row, pixel_col
	input  logic                              s_axis_tlast,   // frame_end
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [plb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // label, box_index, box_found, row_min, row_max, col_min, col_max
	output logic                              m_axis_tlast,   // last
	output logic                              m_axis_tuser    // kind
);
	import plb_pkg::*;

	logic       q_full;
	logic       push;
	plb_entry_t push_entry;
	logic       pop;
	logic       q_valid;
	plb_entry_t head;

	plb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	plb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	plb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
